[sv/blowfish_cipher_engine_core_defines.svh]
// assertion macros for the cipher engine
`ifndef BLOWFISH_CIPHER_ENGINE_CORE_DEFINES_SVH
`define BLOWFISH_CIPHER_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BFCE_ASSERT_NOW(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define BFCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BFCE_ASSERT_NOW(lbl, expr)
`define BFCE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/bfce_pkg.sv]
`timescale 1ns / 1ps

package bfce_pkg;

    localparam int ROUNDS        = 16;
    localparam int PWORDS        = ROUNDS + 2;
    localparam int SBOX_WORDS    = 1024;
    localparam int TABLE_WORDS   = PWORDS + SBOX_WORDS;
    localparam int MAX_KEY_BYTES = 56;
    localparam int BOX_DEPTH     = 256;

    localparam logic [5:0] KEY_LEN_RESET = 6'd16;
    localparam logic [5:0] KEY_LEN_MAX   = 6'd56;
    localparam logic [3:0] LAST_ROUND    = 4'd15;
    localparam logic [4:0] P_LAST        = 5'd17;
    localparam logic [4:0] P_PENULT      = 5'd16;
    localparam logic [1:0] LAST_BYTE     = 2'd3;
    localparam logic [9:0] S_LAST_PAIR   = 10'd1022;
    localparam logic       CFG_KEY_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        FUNC_LOAD_TABLE = 3'd0,
        FUNC_LOAD_KEY   = 3'd1,
        FUNC_KEY_SCHED  = 3'd2,
        FUNC_ENCRYPT    = 3'd3,
        FUNC_DECRYPT    = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_RD,
        ST_KEY_ACC,
        ST_RND_A,
        ST_RND_B,
        ST_FIN1,
        ST_FIN2,
        ST_WR_P,
        ST_WR_S0,
        ST_WR_S1,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       tbl_load;
        logic       key_load;
        logic       key_rd;
        logic       key_acc;
        logic       p_xor;
        logic       load_xy;
        logic       clr_xy;
        logic       round_a;
        logic       round_b;
        logic       fin1;
        logic       fin2;
        logic       p_wr2;
        logic       s_wr;
        logic       s_hi;
        logic       out_load;
        logic       out_kind;
        logic [4:0] p_idx;
        logic [5:0] key_addr;
        logic [9:0] s_addr;
    } cmd_t;

endpackage

[sv/bfce_ram.sv]
`timescale 1ns / 1ps

module bfce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/bfce_datapath.sv]
`timescale 1ns / 1ps

module bfce_datapath (
    input  logic          clk,
    input  bfce_pkg::cmd_t cmd,
    input  logic [10:0]   table_index,
    input  logic [31:0]   table_word,
    input  logic [5:0]    key_index,
    input  logic [7:0]    key_byte,
    input  logic [31:0]   block_left,
    input  logic [31:0]   block_right,
    output logic [31:0]   result_left,
    output logic [31:0]   result_right,
    output logic          result_kind
);

    logic [31:0] p_reg [bfce_pkg::PWORDS];
    logic [31:0] xl_reg, xl_next;
    logic [31:0] xr_reg, xr_next;
    logic [31:0] t_reg;
    logic [23:0] acc_reg;
    logic [31:0] res_l_reg, res_r_reg;
    logic        res_kind_reg;

    logic [31:0] p_sel;
    logic [31:0] t;
    logic [31:0] f;
    logic [31:0] sbox_rdata [4];
    logic [7:0]  key_rdata;
    logic [31:0] key_word;

    logic        load_hit;
    logic [10:0] ld_full;
    logic [9:0]  s_waddr;
    logic [31:0] s_wdata;
    logic        s_we_any;
    logic        key_we;

    assign p_sel    = p_reg[cmd.p_idx];
    assign t        = p_sel ^ xl_reg;
    assign f        = ((sbox_rdata[0] + sbox_rdata[1]) ^ sbox_rdata[2]) + sbox_rdata[3];
    assign key_word = {acc_reg, key_rdata};

    assign load_hit = cmd.tbl_load
        && (table_index >= 11'(bfce_pkg::PWORDS))
        && (table_index < 11'(bfce_pkg::TABLE_WORDS));
    assign ld_full  = table_index - 11'(bfce_pkg::PWORDS);
    assign s_waddr  = cmd.s_wr ? cmd.s_addr : ld_full[9:0];
    assign s_wdata  = cmd.s_wr ? (cmd.s_hi ? xr_reg : xl_reg) : table_word;
    assign s_we_any = cmd.s_wr || load_hit;
    assign key_we   = cmd.key_load && (key_index < 6'(bfce_pkg::MAX_KEY_BYTES));

    for (genvar b = 0; b < 4; b++)
    begin : g_sbox
        bfce_ram #(
            .WIDTH(32),
            .DEPTH(bfce_pkg::BOX_DEPTH)
        ) u_sbox (
            .clk  (clk),
            .we   (s_we_any && (s_waddr[9:8] == 2'(b))),
            .waddr(s_waddr[7:0]),
            .wdata(s_wdata),
            .re   (cmd.round_a),
            .raddr(t[31-8*b -: 8]),
            .rdata(sbox_rdata[b])
        );
    end

    bfce_ram #(
        .WIDTH(8),
        .DEPTH(bfce_pkg::MAX_KEY_BYTES)
    ) u_key (
        .clk  (clk),
        .we   (key_we),
        .waddr(key_index),
        .wdata(key_byte),
        .re   (cmd.key_rd),
        .raddr(cmd.key_addr),
        .rdata(key_rdata)
    );

    always_comb
    begin
        xl_next = xl_reg;
        xr_next = xr_reg;
        if (cmd.load_xy)
        begin
            xl_next = block_left;
            xr_next = block_right;
        end
        else if (cmd.clr_xy)
        begin
            xl_next = '0;
            xr_next = '0;
        end
        else if (cmd.round_b)
        begin
            xl_next = f ^ xr_reg;
            xr_next = t_reg;
        end
        else if (cmd.fin1)
        begin
            xr_next = p_sel ^ xr_reg;
        end
        else if (cmd.fin2)
        begin
            xl_next = xr_reg;
            xr_next = xl_reg ^ p_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        xl_reg <= xl_next;
        xr_reg <= xr_next;
        if (cmd.round_a)
        begin
            t_reg <= t;
        end
        if (cmd.key_acc)
        begin
            acc_reg <= {acc_reg[15:0], key_rdata};
        end
        if (cmd.out_load)
        begin
            res_l_reg    <= xl_reg;
            res_r_reg    <= xr_reg;
            res_kind_reg <= cmd.out_kind;
        end
        for (int i = 0; i < bfce_pkg::PWORDS; i++)
        begin
            if (cmd.tbl_load && (table_index == 11'(i)))
            begin
                p_reg[i] <= table_word;
            end
            if (cmd.p_xor && (cmd.p_idx == 5'(i)))
            begin
                p_reg[i] <= p_reg[i] ^ key_word;
            end
            if (cmd.p_wr2 && (cmd.p_idx == 5'(i)))
            begin
                p_reg[i] <= xl_reg;
            end
            if (cmd.p_wr2 && ((cmd.p_idx + 5'd1) == 5'(i)))
            begin
                p_reg[i] <= xr_reg;
            end
        end
    end

    assign result_left  = res_l_reg;
    assign result_right = res_r_reg;
    assign result_kind  = res_kind_reg;

endmodule

[sv/bfce_ctrl.sv]
`timescale 1ns / 1ps
`include "blowfish_cipher_engine_core_defines.svh"

module bfce_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [2:0]     func,
    input  logic [5:0]     key_length,
    output logic           m_tvalid,
    input  logic           m_tready,
    output bfce_pkg::cmd_t cmd
);

    bfce_pkg::state_t state_reg, state_next;
    logic [3:0] rnd_reg, rnd_next;
    logic       dec_reg, dec_next;
    logic       sched_reg, sched_next;
    logic       sphase_reg, sphase_next;
    logic       kind_reg, kind_next;
    logic [5:0] k_reg, k_next;
    logic [1:0] bc_reg, bc_next;
    logic [4:0] w_reg, w_next;
    logic [4:0] pw_reg, pw_next;
    logic [9:0] s_idx_reg, s_idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [5:0] len_eff;

    always_comb
    begin
        if (key_length == 6'd0)
        begin
            len_eff = 6'd1;
        end
        else if (key_length > bfce_pkg::KEY_LEN_MAX)
        begin
            len_eff = bfce_pkg::KEY_LEN_MAX;
        end
        else
        begin
            len_eff = key_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bfce_pkg::ST_IDLE;
            rnd_reg      <= '0;
            dec_reg      <= 1'b0;
            sched_reg    <= 1'b0;
            sphase_reg   <= 1'b0;
            kind_reg     <= 1'b0;
            k_reg        <= '0;
            bc_reg       <= '0;
            w_reg        <= '0;
            pw_reg       <= '0;
            s_idx_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rnd_reg      <= rnd_next;
            dec_reg      <= dec_next;
            sched_reg    <= sched_next;
            sphase_reg   <= sphase_next;
            kind_reg     <= kind_next;
            k_reg        <= k_next;
            bc_reg       <= bc_next;
            w_reg        <= w_next;
            pw_reg       <= pw_next;
            s_idx_reg    <= s_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rnd_next      = rnd_reg;
        dec_next      = dec_reg;
        sched_next    = sched_reg;
        sphase_next   = sphase_reg;
        kind_next     = kind_reg;
        k_next        = k_reg;
        bc_next       = bc_reg;
        w_next        = w_reg;
        pw_next       = pw_reg;
        s_idx_next    = s_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.key_addr  = k_reg;
        cmd.s_addr    = s_idx_reg;
        cmd.out_kind  = kind_reg;
        cmd.p_idx     = dec_reg ? (bfce_pkg::P_LAST - {1'b0, rnd_reg}) : {1'b0, rnd_reg};

        case (state_reg)
            bfce_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (bfce_pkg::func_t'(func))
                        bfce_pkg::FUNC_LOAD_TABLE: cmd.tbl_load = 1'b1;
                        bfce_pkg::FUNC_LOAD_KEY:   cmd.key_load = 1'b1;
                        bfce_pkg::FUNC_KEY_SCHED:
                        begin
                            k_next     = '0;
                            bc_next    = '0;
                            w_next     = '0;
                            state_next = bfce_pkg::ST_KEY_RD;
                        end
                        bfce_pkg::FUNC_ENCRYPT, bfce_pkg::FUNC_DECRYPT:
                        begin
                            cmd.load_xy = 1'b1;
                            dec_next    = (bfce_pkg::func_t'(func) == bfce_pkg::FUNC_DECRYPT);
                            sched_next  = 1'b0;
                            kind_next   = 1'b0;
                            rnd_next    = '0;
                            state_next  = bfce_pkg::ST_RND_A;
                        end
                        default: ;
                    endcase
                end
            end
            bfce_pkg::ST_KEY_RD:
            begin
                cmd.key_rd = 1'b1;
                k_next     = ((k_reg + 6'd1) >= len_eff) ? 6'd0 : (k_reg + 6'd1);
                state_next = bfce_pkg::ST_KEY_ACC;
            end
            bfce_pkg::ST_KEY_ACC:
            begin
                cmd.p_idx = w_reg;
                bc_next   = bc_reg + 2'd1;
                if (bc_reg == bfce_pkg::LAST_BYTE)
                begin
                    cmd.p_xor = 1'b1;
                    if (w_reg == bfce_pkg::P_LAST)
                    begin
                        cmd.clr_xy  = 1'b1;
                        sched_next  = 1'b1;
                        sphase_next = 1'b0;
                        kind_next   = 1'b1;
                        dec_next    = 1'b0;
                        pw_next     = '0;
                        rnd_next    = '0;
                        state_next  = bfce_pkg::ST_RND_A;
                    end
                    else
                    begin
                        w_next     = w_reg + 5'd1;
                        state_next = bfce_pkg::ST_KEY_RD;
                    end
                end
                else
                begin
                    cmd.key_acc = 1'b1;
                    state_next  = bfce_pkg::ST_KEY_RD;
                end
            end
            bfce_pkg::ST_RND_A:
            begin
                cmd.round_a = 1'b1;
                state_next  = bfce_pkg::ST_RND_B;
            end
            bfce_pkg::ST_RND_B:
            begin
                cmd.round_b = 1'b1;
                rnd_next    = rnd_reg + 4'd1;
                state_next  = (rnd_reg == bfce_pkg::LAST_ROUND) ? bfce_pkg::ST_FIN1
                                                                : bfce_pkg::ST_RND_A;
            end
            bfce_pkg::ST_FIN1:
            begin
                cmd.fin1   = 1'b1;
                cmd.p_idx  = dec_reg ? 5'd0 : bfce_pkg::P_LAST;
                state_next = bfce_pkg::ST_FIN2;
            end
            bfce_pkg::ST_FIN2:
            begin
                cmd.fin2  = 1'b1;
                cmd.p_idx = dec_reg ? 5'd1 : bfce_pkg::P_PENULT;
                if (!sched_reg)
                begin
                    state_next = bfce_pkg::ST_OUT;
                end
                else if (!sphase_reg)
                begin
                    state_next = bfce_pkg::ST_WR_P;
                end
                else
                begin
                    state_next = bfce_pkg::ST_WR_S0;
                end
            end
            bfce_pkg::ST_WR_P:
            begin
                cmd.p_wr2  = 1'b1;
                cmd.p_idx  = pw_reg;
                pw_next    = pw_reg + 5'd2;
                rnd_next   = '0;
                state_next = bfce_pkg::ST_RND_A;
                if (pw_reg == bfce_pkg::P_PENULT)
                begin
                    sphase_next = 1'b1;
                    s_idx_next  = '0;
                end
            end
            bfce_pkg::ST_WR_S0:
            begin
                cmd.s_wr   = 1'b1;
                state_next = bfce_pkg::ST_WR_S1;
            end
            bfce_pkg::ST_WR_S1:
            begin
                cmd.s_wr   = 1'b1;
                cmd.s_hi   = 1'b1;
                cmd.s_addr = s_idx_reg | 10'd1;
                rnd_next   = '0;
                if (s_idx_reg == bfce_pkg::S_LAST_PAIR)
                begin
                    state_next = bfce_pkg::ST_OUT;
                end
                else
                begin
                    s_idx_next = s_idx_reg + 10'd2;
                    state_next = bfce_pkg::ST_RND_A;
                end
            end
            bfce_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = bfce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfce_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

    `BFCE_ASSERT_NEXT(a_last_round_fin, (state_reg == bfce_pkg::ST_RND_B) && (rnd_reg == bfce_pkg::LAST_ROUND), state_reg == bfce_pkg::ST_FIN1)
    `BFCE_ASSERT_NOW(a_key_pos_in_range, (state_reg != bfce_pkg::ST_KEY_RD) || (k_reg < len_eff))
    `BFCE_ASSERT_NOW(a_word_in_range, w_reg <= bfce_pkg::P_LAST)
    `BFCE_ASSERT_NOW(a_sbox_pair_even, s_idx_reg[0] == 1'b0)
    `BFCE_ASSERT_NEXT(a_out_held, m_tvalid_reg && !m_tready, m_tvalid_reg)

endmodule

[sv/blowfish_cipher_engine_core.sv]
`timescale 1ns / 1ps
// blowfish cipher engine: table loads, key loads, key schedule, encrypt and decrypt
// input channel s_*: one item per transfer, func in s_tuser selects the operation
// loads give no result and leave the engine idle; the next item is taken right after
// encrypt or decrypt: 16 rounds (s-box memory read, then the f function), then
// whitening with the last two p words (the first two when decrypting), then the
// result is loaded into the output register; one block at a time
// key schedule: key-byte reads folded into p, then 521 block encryptions whose
// results are written to each p pair and then to each s-box pair, giving one
// result with m_tuser set
// output channel m_*: a held output register; while the receiver stalls the
// result waits there and loads are still taken, a further cipher item waits
// in its final state until the register frees up
// apb port: key_length at address 0, to be written by the user only while the
// engine is idle, which the block does not enforce; reset clears control state and
// sets key_length to 16; p-array, s-boxes and key store are undefined until loaded
module blowfish_cipher_engine_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // table_index, table_word, key_index, key_byte, block_left, block_right, zero pad
    input  logic [127:0] s_tdata,
    // func
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_left, result_right
    output logic [63:0]  m_tdata,
    // result_kind
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    bfce_pkg::cmd_t cmd;
    logic [5:0]  key_length_reg;
    logic        cfg_we;
    logic [31:0] result_left;
    logic [31:0] result_right;
    logic        result_kind;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == bfce_pkg::CFG_KEY_LENGTH);
    assign prdata = (paddr[2] == bfce_pkg::CFG_KEY_LENGTH) ? {26'd0, key_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= bfce_pkg::KEY_LEN_RESET;
        end
        else if (cfg_we)
        begin
            key_length_reg <= pwdata[5:0];
        end
    end

    bfce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (s_tuser),
        .key_length(key_length_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd)
    );

    bfce_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .table_index (s_tdata[10:0]),
        .table_word  (s_tdata[42:11]),
        .key_index   (s_tdata[48:43]),
        .key_byte    (s_tdata[56:49]),
        .block_left  (s_tdata[88:57]),
        .block_right (s_tdata[120:89]),
        .result_left (result_left),
        .result_right(result_right),
        .result_kind (result_kind)
    );

    assign m_tdata = {result_right, result_left};
    assign m_tuser = result_kind;

endmodule

[tb/sv/blowfish_cipher_engine_core_tb.sv]
`timescale 1ns / 1ps

module blowfish_cipher_engine_core_tb;
    import bfce_pkg::*;

    typedef struct {
        logic [31:0] left;
        logic [31:0] right;
        logic        kind;
    } cipher_out_t;

    class cipher_scoreboard;
        logic [31:0] parr [PWORDS];
        logic [31:0] sbox [SBOX_WORDS];
        logic [7:0]  keys [MAX_KEY_BYTES];
        logic [5:0]  key_len;
        cipher_out_t pending [$];
        int          errors;

        function new();
            key_len = KEY_LEN_RESET;
            errors = 0;
        endfunction

        function logic [31:0] feistel_f(logic [31:0] x);
            logic [31:0] s;
            s = sbox[x[31:24]] + sbox[BOX_DEPTH + x[23:16]];
            s = s ^ sbox[2 * BOX_DEPTH + x[15:8]];
            return s + sbox[3 * BOX_DEPTH + x[7:0]];
        endfunction

        function void encipher(inout logic [31:0] l, inout logic [31:0] r);
            logic [31:0] t;
            for (int i = 0; i < ROUNDS; i++)
            begin
                t = parr[i] ^ l;
                l = feistel_f(t) ^ r;
                r = t;
            end
            t = parr[ROUNDS + 1] ^ r;
            r = l ^ parr[ROUNDS];
            l = t;
        endfunction

        function void decipher(inout logic [31:0] l, inout logic [31:0] r);
            logic [31:0] t;
            for (int i = ROUNDS + 1; i > 1; i--)
            begin
                t = parr[i] ^ l;
                l = feistel_f(t) ^ r;
                r = t;
            end
            t = parr[0] ^ r;
            r = l ^ parr[1];
            l = t;
        endfunction

        function void expand_key(output logic [31:0] l, output logic [31:0] r);
            int len;
            int k;
            logic [31:0] w;
            len = key_len;
            if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
            if (len == 0) len = 1;
            k = 0;
            for (int i = 0; i < PWORDS; i++)
            begin
                w = 0;
                for (int b = 0; b < 4; b++)
                begin
                    w = {w[23:0], keys[k]};
                    k = (k + 1 >= len) ? 0 : k + 1;
                end
                parr[i] ^= w;
            end
            l = 0;
            r = 0;
            for (int i = 0; i < PWORDS; i += 2)
            begin
                encipher(l, r);
                parr[i] = l;
                parr[i + 1] = r;
            end
            for (int i = 0; i < SBOX_WORDS; i += 2)
            begin
                encipher(l, r);
                sbox[i] = l;
                sbox[i + 1] = r;
            end
        endfunction

        function void note_input(logic [2:0] fn, logic [10:0] tidx, logic [31:0] tword,
                                 logic [5:0] kidx, logic [7:0] kbyte,
                                 logic [31:0] bl, logic [31:0] br);
            cipher_out_t e;
            e.left = bl;
            e.right = br;
            case (fn)
                FUNC_LOAD_TABLE:
                begin
                    if (tidx < PWORDS) parr[tidx] = tword;
                    else if (tidx < TABLE_WORDS) sbox[tidx - PWORDS] = tword;
                end
                FUNC_LOAD_KEY:
                begin
                    if (kidx < MAX_KEY_BYTES) keys[kidx] = kbyte;
                end
                FUNC_KEY_SCHED:
                begin
                    expand_key(e.left, e.right);
                    e.kind = 1'b1;
                    pending.push_back(e);
                end
                FUNC_ENCRYPT:
                begin
                    encipher(e.left, e.right);
                    e.kind = 1'b0;
                    pending.push_back(e);
                end
                FUNC_DECRYPT:
                begin
                    decipher(e.left, e.right);
                    e.kind = 1'b0;
                    pending.push_back(e);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [31:0] l, logic [31:0] r, logic kind);
            cipher_out_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result left=%h right=%h kind=%0d", l, r, kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (l !== e.left)
            begin
                $error("result_left expected %h actual %h", e.left, l);
                errors++;
            end
            if (r !== e.right)
            begin
                $error("result_right expected %h actual %h", e.right, r);
                errors++;
            end
            if (kind !== e.kind)
            begin
                $error("result_kind expected %0d actual %0d", e.kind, kind);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    cipher_scoreboard sb;

    blowfish_cipher_engine_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(logic [2:0] fn, logic [10:0] tidx, logic [31:0] tword,
                             logic [5:0] kidx, logic [7:0] kbyte,
                             logic [31:0] bl, logic [31:0] br);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {7'd0, br, bl, kbyte, kidx, tword, tidx};
        do @(posedge clk); while (!s_tready);
        sb.note_input(fn, tidx, tword, kidx, kbyte, bl, br);
    endtask

    task automatic load_table(logic [10:0] idx, logic [31:0] w);
        send_item(FUNC_LOAD_TABLE, idx, w, 6'($urandom), 8'($urandom), $urandom, $urandom);
    endtask

    task automatic load_key(logic [5:0] idx, logic [7:0] b);
        send_item(FUNC_LOAD_KEY, 11'($urandom), $urandom, idx, b, $urandom, $urandom);
    endtask

    task automatic cipher(logic [2:0] fn, logic [31:0] bl, logic [31:0] br);
        send_item(fn, 11'($urandom), $urandom, 6'($urandom), 8'($urandom), bl, br);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_key_length(logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'd0;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.key_len = v[5:0];
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // receive side with random stalls
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
        end
    end

    initial
    begin
        logic [5:0] lens [5];
        int r;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_key_length(32'd16);
        // fill every table word and key byte before anything reads them
        for (int i = 0; i < TABLE_WORDS; i++) load_table(i[10:0], $urandom);
        for (int i = 0; i < MAX_KEY_BYTES; i++) load_key(i[5:0], 8'($urandom));

        // directed part
        load_table(11'd0, 32'hffff_ffff);
        load_table(11'd1041, 32'h0);
        load_table(11'd1042, 32'h1234_5678);
        load_table(11'd2047, 32'hdead_beef);
        load_key(6'd0, 8'hff);
        load_key(6'd55, 8'h00);
        load_key(6'd56, 8'h5a);
        load_key(6'd63, 8'ha5);
        cipher(FUNC_ENCRYPT, 32'h0, 32'h0);
        cipher(FUNC_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
        cipher(FUNC_DECRYPT, 32'h0, 32'hffff_ffff);
        cipher(FUNC_DECRYPT, 32'hffff_ffff, 32'h0);
        send_item(3'd5, 11'd3, $urandom, 6'd1, 8'($urandom), $urandom, $urandom);
        send_item(3'd6, 11'd20, $urandom, 6'd2, 8'($urandom), $urandom, $urandom);
        send_item(3'd7, 11'd0, $urandom, 6'd0, 8'($urandom), $urandom, $urandom);
        cipher(FUNC_KEY_SCHED, $urandom, $urandom);
        cipher(FUNC_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
        cipher(FUNC_DECRYPT, 32'h0123_4567, 32'h89ab_cdef);
        drain();

        lens[0] = 6'd1;
        lens[1] = 6'd56;
        lens[2] = 6'd0;
        lens[3] = 6'd63;
        lens[4] = 6'($urandom_range(2, 55));
        for (int ph = 0; ph < 5; ph++)
        begin
            write_key_length({26'd0, lens[ph]});
            cipher(FUNC_KEY_SCHED, $urandom, $urandom);
            for (int n = 0; n < 140; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    load_table($urandom_range(0, 9) == 0 ? 11'($urandom) :
                               11'($urandom_range(0, TABLE_WORDS - 1)), pick_word());
                else if (r < 35)
                    load_key($urandom_range(0, 9) == 0 ? 6'($urandom) :
                             6'($urandom_range(0, MAX_KEY_BYTES - 1)), 8'($urandom));
                else if (r < 66)
                    cipher(FUNC_ENCRYPT, pick_word(), pick_word());
                else if (r < 97)
                    cipher(FUNC_DECRYPT, pick_word(), pick_word());
                else if (r < 98)
                    cipher(FUNC_KEY_SCHED, $urandom, $urandom);
                else
                    send_item(3'($urandom_range(5, 7)), 11'($urandom), $urandom,
                              6'($urandom), 8'($urandom), $urandom, $urandom);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/bfce_pkg.sv
sv/bfce_ram.sv
sv/bfce_datapath.sv
sv/bfce_ctrl.sv
sv/blowfish_cipher_engine_core.sv
tb/sv/blowfish_cipher_engine_core_tb.sv
